[rtl/lbp_pkg.sv]
// Package for the LSB-first bit packer: field widths, mode codes and the
// metadata struct that travels with each queued byte group. No dependencies.
package lbp_pkg;

	localparam int BYTE_W      = 8;
	localparam int BIT_IDX_MAX = BYTE_W - 1;
	localparam int HCNT_W      = $clog2(BYTE_W);
	localparam int VALUE_W     = 64;
	localparam int COUNT_W     = 7;
	localparam int TOTAL_W     = 32;
	localparam int MODE_W      = 2;
	localparam int S_TDATA_W   = 72;
	localparam int M_TDATA_W   = 40;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE   = 2'd0,
		MODE_ALIGN   = 2'd1,
		MODE_RESTART = 2'd2
	} lbp_mode_t;

	typedef struct packed {
		logic               err;
		logic [TOTAL_W-1:0] total;
	} lbp_meta_t;

endpackage

[rtl/lbp_front.sv]
// Front end of the bit packer: accepts input words, holds the partial byte
// and the bit total, and turns each item that completes bytes into a group
// of whole bytes; an error item gives a single zero byte. Depends on lbp_pkg.
module lbp_front import lbp_pkg::*; #(
	parameter int MAX_FIELD_BITS = 64,
	parameter int DATA_W         = 64,
	parameter int NB_W           = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_accept,
	input  logic [MODE_W-1:0]      in_mode,
	input  logic [VALUE_W-1:0]     in_value,
	input  logic [COUNT_W-1:0]     in_count,
	output logic                   push_valid,
	output logic [DATA_W-1:0]      push_data,
	output logic [NB_W-1:0]        push_nbytes,
	output lbp_meta_t              push_meta
);

	localparam int ACC_W = MAX_FIELD_BITS + BIT_IDX_MAX;

	logic [BIT_IDX_MAX-1:0] held_bits_q;
	logic [HCNT_W-1:0]      held_count_q;
	logic [TOTAL_W-1:0]     bit_total_q;

	logic [BIT_IDX_MAX-1:0] held_bits_d;
	logic [HCNT_W-1:0]      held_count_d;
	logic [TOTAL_W-1:0]     bit_total_d;

	logic                      cnt_ok;
	logic [COUNT_W-1:0]        mask_sh;
	logic [MAX_FIELD_BITS-1:0] masked;
	logic [ACC_W-1:0]          acc;
	logic [ACC_W-1:0]          rest;
	logic [COUNT_W:0]          bit_sum;
	logic [NB_W-1:0]           nbytes;
	logic [HCNT_W-1:0]         rem;
	logic [BIT_IDX_MAX-1:0]    rem_mask;
	lbp_mode_t                 mode;

	assign mode    = lbp_mode_t'(in_mode);
	assign cnt_ok  = (in_count != '0) && (in_count <= COUNT_W'(MAX_FIELD_BITS));
	assign mask_sh = COUNT_W'(MAX_FIELD_BITS) - in_count;
	assign masked  = in_value[MAX_FIELD_BITS-1:0] & ({MAX_FIELD_BITS{1'b1}} >> mask_sh);

	// New bits go in right above the held ones.
	assign acc      = (ACC_W'(masked) << held_count_q) | ACC_W'(held_bits_q);
	assign bit_sum  = (COUNT_W+1)'(held_count_q) + (COUNT_W+1)'(in_count);
	assign nbytes   = NB_W'(bit_sum >> HCNT_W);
	assign rem      = bit_sum[HCNT_W-1:0];
	assign rest     = acc >> (nbytes * BYTE_W);
	assign rem_mask = {BIT_IDX_MAX{1'b1}} >> (HCNT_W'(BIT_IDX_MAX) - rem);

	always_comb begin
		held_bits_d  = held_bits_q;
		held_count_d = held_count_q;
		bit_total_d  = bit_total_q;
		push_valid   = 1'b0;
		push_data    = '0;
		push_nbytes  = NB_W'(1);
		push_meta    = '{err: 1'b0, total: bit_total_q};
		unique case (mode)
			MODE_WRITE: begin
				if (!cnt_ok) begin
					push_valid     = in_accept;
					push_meta.err  = 1'b1;
				end else begin
					bit_total_d     = bit_total_q + TOTAL_W'(in_count);
					held_bits_d     = rest[BIT_IDX_MAX-1:0] & rem_mask;
					held_count_d    = rem;
					push_valid      = in_accept && (nbytes != '0);
					push_data       = acc[DATA_W-1:0];
					push_nbytes     = nbytes;
					push_meta.total = bit_total_d;
				end
			end
			MODE_ALIGN: begin
				if (held_count_q != '0) begin
					bit_total_d     = bit_total_q + TOTAL_W'(BYTE_W)
					                - TOTAL_W'(held_count_q);
					held_bits_d     = '0;
					held_count_d    = '0;
					push_valid      = in_accept;
					push_data       = DATA_W'(held_bits_q);
					push_meta.total = bit_total_d;
				end
			end
			MODE_RESTART: begin
				held_bits_d  = '0;
				held_count_d = '0;
				bit_total_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q  <= '0;
			held_count_q <= '0;
			bit_total_q  <= '0;
		end else if (in_accept) begin
			held_bits_q  <= held_bits_d;
			held_count_q <= held_count_d;
			bit_total_q  <= bit_total_d;
		end
	end

endmodule

[rtl/lbp_queue.sv]
// Two-entry queue between the front and back ends of the bit packer.
// Plain valid/ready on both sides. Depends on nothing.
module lbp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/lbp_back.sv]
// Back end of the bit packer: takes one byte group from the queue and sends
// its bytes one per word, lowest first, with last on the final one.
// Depends on lbp_pkg.
module lbp_back import lbp_pkg::*; #(
	parameter int DATA_W = 64,
	parameter int NB_W   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  logic [DATA_W-1:0]    q_data,
	input  logic [NB_W-1:0]      q_nbytes,
	input  lbp_meta_t            q_meta,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_last,
	output lbp_meta_t            out_meta
);

	logic [DATA_W-1:0] data_q;
	logic [NB_W-1:0]   left_q;
	lbp_meta_t         meta_q;
	logic              advance;

	assign out_valid = (left_q != '0);
	assign out_last  = (left_q == NB_W'(1));
	assign out_byte  = data_q[BYTE_W-1:0];
	assign out_meta  = meta_q;
	assign advance   = out_valid && out_ready;
	assign q_ready   = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (q_ready) begin
			left_q <= q_valid ? q_nbytes : '0;
		end else if (advance) begin
			left_q <= left_q - NB_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			data_q <= q_data;
			meta_q <= q_meta;
		end else if (advance) begin
			data_q <= data_q >> BYTE_W;
		end
	end

endmodule

[rtl/lsb_first_bit_packer_unit.sv]
// Top level of the LSB-first bit packer: front end, byte-group queue and
// byte serializer. Depends on lbp_pkg, lbp_front, lbp_queue and lbp_back.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata: value, bit_count; s_tuser: mode
// m_*      out  m_tvalid/m_tready   m_tdata: out_byte, total_bits; m_tlast: last;
//                                   m_tuser: error
//
// An input word is taken whenever the queue has room; it is turned into a
// group of up to eight bytes at once. Items that give no byte are not
// queued. The serializer sends one byte per cycle while m_tready is high,
// and takes the next group from the queue as it sends the last byte of the
// current one. Reset clears the partial byte, the bit total and the queue.
// A stall on the output fills the queue and then holds s_tready low.
module lsb_first_bit_packer_unit import lbp_pkg::*; #(
	parameter int MAX_FIELD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Fields from bit 0 up: value (64), bit_count (7), one zero pad bit.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0 up: mode (2).
	input  logic [MODE_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// Fields from bit 0 up: out_byte (8), total_bits (32).
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	// Fields from bit 0 up: error (1).
	output logic [0:0]           m_tuser
);

	// Widest byte group one item can complete, and its count width.
	localparam int MAX_BYTES = (MAX_FIELD_BITS + BIT_IDX_MAX) / BYTE_W;
	localparam int DATA_W    = MAX_BYTES * BYTE_W;
	localparam int NB_W      = $clog2(MAX_BYTES + 1);
	localparam int META_W    = $bits(lbp_meta_t);
	localparam int Q_W       = DATA_W + NB_W + META_W;

	logic              in_accept;
	logic              push_valid;
	logic [DATA_W-1:0] push_data;
	logic [NB_W-1:0]   push_nbytes;
	lbp_meta_t         push_meta;
	logic              pop_valid;
	logic              pop_ready;
	logic [Q_W-1:0]    pop_word;
	logic [DATA_W-1:0] pop_data;
	logic [NB_W-1:0]   pop_nbytes;
	lbp_meta_t         pop_meta;
	logic [BYTE_W-1:0] out_byte;
	lbp_meta_t         out_meta;

	assign in_accept = s_tvalid && s_tready;

	lbp_front #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS),
		.DATA_W         (DATA_W),
		.NB_W           (NB_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.in_mode     (s_tuser),
		.in_value    (s_tdata[VALUE_W-1:0]),
		.in_count    (s_tdata[VALUE_W+COUNT_W-1:VALUE_W]),
		.push_valid  (push_valid),
		.push_data   (push_data),
		.push_nbytes (push_nbytes),
		.push_meta   (push_meta)
	);

	// The queue only takes a group when a word is accepted, and a word is
	// accepted only when the queue has room, so no push is ever refused.
	lbp_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (s_tready),
		.wr_data  ({push_meta, push_nbytes, push_data}),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_word)
	);

	assign pop_data   = pop_word[DATA_W-1:0];
	assign pop_nbytes = pop_word[DATA_W+NB_W-1:DATA_W];
	assign pop_meta   = lbp_meta_t'(pop_word[Q_W-1:DATA_W+NB_W]);

	lbp_back #(
		.DATA_W (DATA_W),
		.NB_W   (NB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_data    (pop_data),
		.q_nbytes  (pop_nbytes),
		.q_meta    (pop_meta),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_last  (m_tlast),
		.out_meta  (out_meta)
	);

	// Error words carry a zero byte, which the front end already supplies.
	assign m_tdata = {out_meta.total, out_byte};
	assign m_tuser = out_meta.err;

endmodule

[rtl/lbp_checker.sv]
// Port-level checks for the bit packer top level, attached by bind.
// Depends on lbp_pkg and lsb_first_bit_packer_unit.
module lbp_checker import lbp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [MODE_W-1:0]    s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tlast,
	input logic [0:0]           m_tuser
);

	// A stalled input word stays offered and holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("stalled input word changed");

	// A stalled output word holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("stalled output word changed");

	// An error word is alone in its item and carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata[BYTE_W-1:0] == '0))
		else $error("error word malformed");

	// Bytes of one item follow without a gap and share one bit total.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser[0]
		&& (m_tdata[M_TDATA_W-1:BYTE_W] == $past(m_tdata[M_TDATA_W-1:BYTE_W])))
		else $error("byte group broken");

	// Input back-pressure only arises while the output has a word pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with idle output");

endmodule

bind lsb_first_bit_packer_unit lbp_checker u_lbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
